FILE: src/taps_pkg.sv
`timescale 1ns / 1ps
// Package for the two-bank priority scheduler.
// Sizes, opcodes and the bonus constants; no dependencies.
package taps_pkg;
  localparam int ProcSlots = 64;
  localparam int PrioLevels = 40;
  localparam int PidW = 6;
  localparam int LvlW = 6;
  localparam int QW = 7;
  localparam logic [3:0] BonusIdle = 4'd4;
  localparam logic [5:0] PrioCap = 6'd39;
  localparam logic OpInsert = 1'b0;
  localparam logic OpGet = 1'b1;
endpackage

FILE: src/two_array_priority_scheduler_top.sv
`timescale 1ns / 1ps
// Top level of the two-bank priority scheduler.
// Uses taps_pkg. Holds the level memories, divider and scan sequencer.
//
// Usage: one input channel (in_valid/in_stall) carries a request word: insert
// (operation=0) or get (operation=1). One output channel (out_valid/
// out_stall) returns one result word per request. Requests are handled one at
// a time; in_stall stays high while a request is in progress or a result
// waits.
// Insert: a 36-step restoring divider forms sleep*10/(sleep+run), one
// quotient bit a cycle, then the level tables are updated and the result
// word is issued.
// Get: the active bank's valid bits are scanned one level a cycle (up to 40
// levels), then the other bank after a swap, followed by the table reads of
// the head and its link. The next request is taken only once the result
// word has been taken and the block is back in idle.
// Reset clears the bank pointer, all head/tail valid bits and the per-process
// last-bank bits at once; no clearing pass. A stalled result holds its value
// until taken; the next request is not taken before that.
module two_array_priority_scheduler_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  logic [5:0]           proc_id,
  input  logic [5:0]           base_priority,
  input  logic [31:0]          sleep_ticks,
  input  logic [31:0]          run_ticks,
  input  logic                 to_active,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 found,
  output logic [5:0]           out_proc_id,
  output logic                 out_bank,
  output logic [5:0]           out_dyn_priority
);
  import taps_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DIV   = 8'b00000010,
    S_INS   = 8'b00000100,
    S_SCAN  = 8'b00001000,
    S_RDH   = 8'b00010000,
    S_POP   = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_WRT   = 8'b10000000
  } state_t;

  state_t state;

  // Request registers
  logic [PidW-1:0] pid;
  logic [5:0]      base;
  logic            to_act;
  logic            act_bank;
  logic            last_bank [ProcSlots];

  // Head/tail ids live in memories, validity in flip-flops
  logic [PidW-1:0] head_mem [2*PrioLevels];
  logic [PidW-1:0] tail_mem [2*PrioLevels];
  logic [PidW-1:0] next_mem [ProcSlots];
  logic            next_vld_mem [ProcSlots];
  logic [2*PrioLevels-1:0] head_vld;
  logic [2*PrioLevels-1:0] tail_vld;

  // Divider: numerator sleep*10 (36 bits), denominator sleep+run (33 bits)
  logic [35:0] num;
  logic [33:0] rem;
  logic [32:0] den;
  logic [3:0]  quo;
  logic [5:0]  div_cnt;
  logic [33:0] rem_sh;
  logic        idle_case;

  logic [QW-1:0]  q;
  logic [LvlW-1:0] lvl;
  logic            bank;
  logic            swapped;
  logic [PidW-1:0] rd_head;
  logic [PidW-1:0] rd_tail;
  logic [PidW-1:0] rd_next;
  logic            rd_next_vld;
  logic [6:0]      dsum;
  logic [6:0]      dclamp;

  assign rem_sh = {rem[32:0], num[35]};
  assign in_stall = (state != S_IDLE);
  assign q = bank ? QW'(lvl) + QW'(PrioLevels) : QW'(lvl);

  // Dynamic priority from the finished quotient
  always_comb begin
    dsum = {1'b0, base} + 7'(BonusIdle) - 7'(idle_case ? BonusIdle : quo);
    if (7'({1'b0, base}) + 7'(BonusIdle) < 7'(idle_case ? BonusIdle : quo)) dclamp = '0;
    else if (dsum > 7'(PrioCap)) dclamp = 7'(PrioCap);
    else dclamp = dsum;
  end

  // Table read ports, registered
  always_ff @(posedge clk) begin
    rd_head <= head_mem[q];
    rd_tail <= tail_mem[q];
    rd_next <= next_mem[rd_head];
    rd_next_vld <= next_vld_mem[rd_head];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act_bank <= 1'b0;
      head_vld <= '0;
      tail_vld <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < ProcSlots; i++) last_bank[i] <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pid <= proc_id;
            base <= base_priority;
            to_act <= to_active;
            num <= {sleep_ticks, 3'b000} + {3'b000, sleep_ticks, 1'b0};
            den <= {1'b0, sleep_ticks} + {1'b0, run_ticks};
            idle_case <= (sleep_ticks == '0) && (run_ticks == '0);
            rem <= '0;
            quo <= '0;
            div_cnt <= '0;
            lvl <= '0;
            swapped <= 1'b0;
            if (operation == OpInsert) begin
              state <= S_DIV;
            end else begin
              bank <= act_bank;
              state <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          // One quotient bit per cycle; quotient never exceeds 10 unless both tick counts are zero
          num <= {num[34:0], 1'b0};
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            quo <= {quo[2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[2:0], 1'b0};
          end
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd35) state <= S_WRT;
        end
        S_WRT: begin
          // Pick level and bank, let the table reads settle
          lvl <= dclamp[LvlW-1:0];
          bank <= to_act ? act_bank : ~last_bank[pid];
          state <= S_INS;
          div_cnt <= '0;
        end
        S_INS: begin
          // First cycle: clear own link while the tail read lands; then update
          if (div_cnt == 6'd0) begin
            next_vld_mem[pid] <= 1'b0;
            div_cnt <= 6'd1;
          end else begin
            if (!head_vld[q] || !tail_vld[q]) begin
              head_mem[q] <= pid;
              head_vld[q] <= 1'b1;
            end else begin
              next_mem[rd_tail] <= pid;
              next_vld_mem[rd_tail] <= 1'b1;
            end
            tail_mem[q] <= pid;
            tail_vld[q] <= 1'b1;
            found <= 1'b1;
            out_proc_id <= '0;
            out_bank <= bank;
            out_dyn_priority <= lvl;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_SCAN: begin
          // One level of one bank per cycle
          if (head_vld[q]) begin
            state <= S_RDH;
          end else if (lvl == LvlW'(PrioLevels - 1)) begin
            lvl <= '0;
            if (!swapped) begin
              swapped <= 1'b1;
              act_bank <= ~act_bank;
              bank <= ~bank;
            end else begin
              found <= 1'b0;
              out_proc_id <= '0;
              out_bank <= act_bank;
              out_dyn_priority <= '0;
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            lvl <= lvl + LvlW'(1);
          end
        end
        S_RDH: begin
          // rd_head now valid; next read lands next cycle
          state <= S_POP;
          div_cnt <= '0;
        end
        S_POP: begin
          if (div_cnt == 6'd0) begin
            div_cnt <= 6'd1;
          end else begin
            last_bank[rd_head] <= bank;
            head_mem[q] <= rd_next;
            head_vld[q] <= rd_next_vld;
            if (!rd_next_vld) tail_vld[q] <= 1'b0;
            found <= 1'b1;
            out_proc_id <= rd_head;
            out_bank <= act_bank;
            out_dyn_priority <= lvl;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: dv/two_array_priority_scheduler_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the two-bank priority scheduler top level.
// Uses taps_pkg; self-checking against a behavioral scheduler model held in a class.

// Scheduler model plus queue of predicted result words.
class sched_scoreboard;
  typedef struct packed {
    logic       found;
    logic [5:0] pid;
    logic       bank;
    logic [5:0] lvl;
  } sched_word_t;

  bit         act_bank;
  bit         head_vld[2][taps_pkg::PrioLevels];
  bit [5:0]   head_id[2][taps_pkg::PrioLevels];
  bit         tail_vld[2][taps_pkg::PrioLevels];
  bit [5:0]   tail_id[2][taps_pkg::PrioLevels];
  bit         link_vld[taps_pkg::ProcSlots];
  bit [5:0]   link_id[taps_pkg::ProcSlots];
  bit         last_bank[taps_pkg::ProcSlots];
  sched_word_t pending_words[$];
  int         mismatches;

  function new();
    act_bank = 0;
    mismatches = 0;
    foreach (head_vld[b, l]) begin
      head_vld[b][l] = 0;
      tail_vld[b][l] = 0;
    end
    foreach (last_bank[p]) begin
      last_bank[p] = 0;
      link_vld[p] = 0;
    end
  endfunction

  // Level from base priority and the sleep/run bonus.
  function bit [5:0] level_of(bit [5:0] base, bit [31:0] slp, bit [31:0] run);
    longint unsigned bonus, sum, d;
    bonus = 4;
    if (slp != 0 || run != 0)
      bonus = (longint'(slp) * 10) / (longint'(slp) + longint'(run));
    sum = base + 4;
    d = (sum > bonus) ? sum - bonus : 0;
    if (d > 39) d = 39;
    return d[5:0];
  endfunction

  function bit pop_level(bit bank, output bit [5:0] lvl, output bit [5:0] pid);
    for (int i = 0; i < taps_pkg::PrioLevels; i++) begin
      if (head_vld[bank][i]) begin
        pid = head_id[bank][i];
        last_bank[pid] = bank;
        head_vld[bank][i] = link_vld[pid];
        head_id[bank][i] = link_id[pid];
        if (!link_vld[pid]) tail_vld[bank][i] = 0;
        lvl = 6'(i);
        return 1;
      end
    end
    return 0;
  endfunction

  // Apply one accepted request and queue its result word.
  function void note_request(bit op, bit [5:0] pid, bit [5:0] base, bit [31:0] slp,
                             bit [31:0] run, bit to_act);
    sched_word_t w;
    bit          bank, got;
    bit [5:0]    lvl, p;
    w = '0;
    if (op == taps_pkg::OpInsert) begin
      lvl = level_of(base, slp, run);
      bank = to_act ? act_bank : !last_bank[pid];
      link_vld[pid] = 0;
      link_id[pid] = 0;
      if (!head_vld[bank][lvl] || !tail_vld[bank][lvl]) begin
        head_vld[bank][lvl] = 1;
        head_id[bank][lvl] = pid;
      end else begin
        link_vld[tail_id[bank][lvl]] = 1;
        link_id[tail_id[bank][lvl]] = pid;
      end
      tail_vld[bank][lvl] = 1;
      tail_id[bank][lvl] = pid;
      w.found = 1;
      w.bank = bank;
      w.lvl = lvl;
    end else begin
      got = pop_level(act_bank, lvl, p);
      if (!got) begin
        act_bank = !act_bank;
        got = pop_level(act_bank, lvl, p);
      end
      w.bank = act_bank;
      if (got) begin
        w.found = 1;
        w.pid = p;
        w.lvl = lvl;
      end
    end
    pending_words.push_back(w);
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task check_result(bit f, bit [5:0] pid, bit b, bit [5:0] lvl);
    sched_word_t w;
    if (pending_words.size() == 0) begin
      report("result word with nothing expected");
      return;
    end
    w = pending_words.pop_front();
    if (f !== w.found) report($sformatf("found %0b exp %0b", f, w.found));
    if (pid !== w.pid) report($sformatf("proc_id %0d exp %0d", pid, w.pid));
    if (b !== w.bank) report($sformatf("bank %0b exp %0b", b, w.bank));
    if (lvl !== w.lvl) report($sformatf("dyn_priority %0d exp %0d", lvl, w.lvl));
  endtask
endclass

module two_array_priority_scheduler_top_tb;
  import taps_pkg::*;

  localparam int IdleLimit = 20000;

  logic        clk, rst;
  logic        in_valid, in_stall, operation, to_active;
  logic [5:0]  proc_id, base_priority;
  logic [31:0] sleep_ticks, run_ticks;
  logic        out_valid, out_stall, found, out_bank;
  logic [5:0]  out_proc_id, out_dyn_priority;

  sched_scoreboard sb;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_recv;
  int  quiet_cycles;
  bit  all_sent;

  two_array_priority_scheduler_top i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watch accepted words on both channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_request(operation, proc_id, base_priority, sleep_ticks, run_ticks,
                        to_active);
      if (out_valid && !out_stall)
        sb.check_result(found, out_proc_id, out_bank, out_dyn_priority);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (quiet_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver stall, changed at the falling edge.
  always @(negedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // Send one request word; waits for acceptance. Valid stays up for the
  // next word; the caller drops it when a run of words ends.
  task send_word(bit op, bit [5:0] pid, bit [5:0] base, bit [31:0] slp, bit [31:0] run,
                 bit to_act);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    operation <= op;
    proc_id <= pid;
    base_priority <= base;
    sleep_ticks <= slp;
    run_ticks <= run;
    to_active <= to_act;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function bit [31:0] rand_ticks();
    case ($urandom_range(5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(20);
      3: return $urandom_range(2000);
      default: return $urandom;
    endcase
  endfunction

  task random_words(int n);
    bit [5:0] pid;
    for (int i = 0; i < n; i++) begin
      pid = 6'($urandom_range(63));
      if ($urandom_range(99) < 55)
        send_word(OpInsert, pid,
                  $urandom_range(63) < 56 ? 6'($urandom_range(39)) : 6'($urandom),
                  rand_ticks(), rand_ticks(), 1'($urandom));
      else
        send_word(OpGet, 6'($urandom), 6'($urandom), $urandom, $urandom, 1'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0; operation = 0; proc_id = 0; base_priority = 0;
    sleep_ticks = 0; run_ticks = 0; to_active = 0;
    out_stall = 0; hold_recv = 0; quiet_cycles = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: empty get, bonus extremes, bank choices, FIFO order.
    send_word(OpGet, 0, 0, 0, 0, 0);
    send_word(OpGet, 63, 63, '1, '1, 1);
    send_word(OpInsert, 0, 0, 0, 0, 1);
    send_word(OpInsert, 63, 39, 0, 0, 0);
    send_word(OpInsert, 5, 63, '1, '1, 1);
    send_word(OpInsert, 6, 0, '1, 0, 1);
    send_word(OpInsert, 7, 39, 0, '1, 0);
    send_word(OpInsert, 8, 20, 32'hFFFF_FFFF, 1, 1);
    send_word(OpInsert, 9, 20, 3, 7, 1);
    send_word(OpInsert, 10, 20, 3, 7, 1);
    send_word(OpInsert, 9, 20, 3, 7, 1);
    send_word(OpInsert, 42, 52, 1, 0, 0);
    for (int i = 0; i < 11; i++) send_word(OpGet, 0, 0, 0, 0, 0);

    send_idle_pct = 11; recv_idle_pct = 45;
    random_words(550);
    // Long receiver hold-off while requests keep coming.
    fork
      begin
        hold_recv = 1;
        repeat (400) @(posedge clk);
        hold_recv = 0;
      end
      begin
        random_words(20);
        in_valid <= 0;
      end
    join
    @(negedge clk);
    send_idle_pct = 45; recv_idle_pct = 11;
    random_words(530);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_words(530);
    in_valid <= 0;

    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
